@@ rtl/gsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared types and constants of the greedy set cover engine.
// ----------------------------------------------------------------------------
package gsc_pkg;

  localparam int GSC_MAX_SETS     = 64;
  localparam int GSC_MAX_ELEMENTS = 64;
  localparam int MASK_W           = 64;
  localparam int NUM_W            = 7;
  localparam int SET_IDX_W        = 6;
  localparam int GAIN_W           = 7;

  localparam logic [NUM_W-1:0] NUM_ELEMENTS_RESET = NUM_W'(64);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_EMIT
  } gsc_state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic emit;
    logic finish;
  } gsc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic no_gain;
    logic cover_full;
  } gsc_status_t;

endpackage

@@ rtl/gsc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module gsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/gsc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_dp
// Datapath: set row store, sweep pipeline, best-gain tracking, covered mask
// and result registers.
// ----------------------------------------------------------------------------
module gsc_dp #(
  parameter int MAX_SETS = gsc_pkg::GSC_MAX_SETS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gsc_pkg::NUM_W-1:0]         cfg_data,
  input  logic [gsc_pkg::MASK_W-1:0]        member_mask,
  input  gsc_pkg::gsc_cmd_t                 cmd,
  output gsc_pkg::gsc_status_t              status,
  output logic [gsc_pkg::SET_IDX_W-1:0]     chosen_set,
  output logic [gsc_pkg::GAIN_W-1:0]        gain,
  output logic                              last_pick,
  output logic                              no_cover
);
  import gsc_pkg::*;

  localparam int AW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int CW   = $clog2(MAX_SETS + 1);
  localparam int IDXW = (AW > SET_IDX_W) ? AW : SET_IDX_W;

  function automatic logic [GAIN_W-1:0] popcount(input logic [MASK_W-1:0] v);
    logic [GAIN_W-1:0] c;
    c = '0;
    for (int k = 0; k < MASK_W; k++) begin
      c = c + GAIN_W'(v[k]);
    end
    return c;
  endfunction

  logic [NUM_W-1:0]  num_elements;
  logic [NUM_W-1:0]  n_clamp;
  logic [MASK_W-1:0] uni;
  logic [MASK_W-1:0] covered;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     raddr;
  logic              scanning;
  logic              v1;
  logic              v2;
  logic [AW-1:0]     idx1;
  logic [AW-1:0]     idx2;
  logic [MASK_W-1:0] rdata;
  logic [MASK_W-1:0] masked;
  logic [GAIN_W-1:0] masked_gain;
  logic [GAIN_W-1:0] best;
  logic [AW-1:0]     best_idx;
  logic [MASK_W-1:0] best_row;
  logic [IDXW-1:0]   best_idx_ext;
  logic              ram_we;

  always_comb begin
    n_clamp = num_elements;
    if (num_elements == '0) begin
      n_clamp = NUM_W'(1);
    end else if (num_elements > NUM_W'(GSC_MAX_ELEMENTS)) begin
      n_clamp = NUM_W'(GSC_MAX_ELEMENTS);
    end
    for (int k = 0; k < MASK_W; k++) begin
      uni[k] = (NUM_W'(k) < n_clamp);
    end
  end

  assign ram_we = cmd.load && (cnt < CW'(MAX_SETS));

  gsc_ram #(
    .WIDTH(MASK_W),
    .DEPTH(MAX_SETS)
  ) u_set_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt[AW-1:0]),
    .wdata(member_mask),
    .re   (scanning),
    .raddr(raddr[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_elements <= NUM_ELEMENTS_RESET;
    end else if (cfg_we) begin
      num_elements <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.finish) begin
      cnt <= '0;
    end else if (ram_we) begin
      cnt <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      raddr    <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
    end else begin
      v1 <= scanning;
      v2 <= v1;
      if (cmd.scan_start) begin
        scanning <= 1'b1;
        raddr    <= '0;
      end else if (scanning) begin
        raddr <= raddr + CW'(1);
        if (raddr == cnt - CW'(1)) begin
          scanning <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1   <= raddr[AW-1:0];
    idx2   <= idx1;
    masked <= rdata & uni & ~covered;
  end

  assign masked_gain = popcount(masked);

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best     <= '0;
      best_idx <= '0;
      best_row <= '0;
    end else if (v2 && (masked_gain > best)) begin
      best     <= masked_gain;
      best_idx <= idx2;
      best_row <= masked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      covered <= '0;
    end else if (cmd.finish) begin
      covered <= '0;
    end else if (cmd.emit) begin
      covered <= covered | best_row;
    end
  end

  assign status.scan_done  = !scanning && !v1 && !v2;
  assign status.no_gain    = (best == '0);
  assign status.cover_full = (((covered | best_row) & uni) == uni);

  assign best_idx_ext = IDXW'(best_idx);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      chosen_set <= best_idx_ext[SET_IDX_W-1:0];
      gain       <= best;
      no_cover   <= status.no_gain;
      last_pick  <= status.no_gain || status.cover_full;
    end
  end

endmodule

@@ rtl/gsc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_ctrl
// Controller: load phase, per-pick sweep sequencing and result handshake.
// ----------------------------------------------------------------------------
module gsc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 last_set,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gsc_pkg::gsc_cmd_t    cmd,
  input  gsc_pkg::gsc_status_t status
);
  import gsc_pkg::*;

  gsc_state_t state;
  gsc_state_t state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last_set) begin
            state_next = ST_START;
          end
        end
      end
      ST_START: begin
        cmd.scan_start = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          if (status.no_gain || status.cover_full) begin
            cmd.finish = 1'b1;
            state_next = ST_LOAD;
          end else begin
            state_next = ST_START;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

@@ rtl/greedy_set_cover.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_set_cover
// Greedy set cover: loads set rows, then emits picks until covered or no gain.
// ----------------------------------------------------------------------------
// Set rows load one beat per cycle into a MAX_SETS-row memory. The beat with
// last_set high closes the load; input then stalls while the cover run goes.
// Each pick sweeps every loaded row through the single memory read port, one
// row per cycle; a run makes at most one pick per element, and each pick
// waits for the result handshake. The last result of a run may still sit in
// the output register while the next load starts. num_elements is written over
// the config channel, which is always ready.
// ----------------------------------------------------------------------------
module greedy_set_cover #(
  parameter int MAX_SETS = gsc_pkg::GSC_MAX_SETS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gsc_pkg::NUM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gsc_pkg::MASK_W-1:0]    member_mask,
  input  logic                          last_set,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gsc_pkg::SET_IDX_W-1:0] chosen_set,
  output logic [gsc_pkg::GAIN_W-1:0]    gain,
  output logic                          last_pick,
  output logic                          no_cover
);
  import gsc_pkg::*;

  gsc_cmd_t    cmd;
  gsc_status_t status;

  assign cfg_ready = 1'b1;

  gsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last_set (last_set),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .status   (status)
  );

  gsc_dp #(
    .MAX_SETS(MAX_SETS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .member_mask(member_mask),
    .cmd        (cmd),
    .status     (status),
    .chosen_set (chosen_set),
    .gain       (gain),
    .last_pick  (last_pick),
    .no_cover   (no_cover)
  );

endmodule
